// File: sv/hzr_pkg.sv
// haze removal pixel recovery: shared widths, constants and codes
// no dependencies; compiled first

package hzr_pkg;

  localparam int CW   = 16;  // input sample width, Q0.16
  localparam int OW   = 20;  // result width, signed Q3.16
  localparam int IDXW = 3;   // config register index width
  localparam int DATW = 48;  // config write data width

  localparam logic [32:0] OFFSET_A = 33'd4299262263;  // 1.001 in Q.32
  localparam logic [32:0] OFFSET_B = 33'd4294971591;  // 1.000001 in Q.32
  localparam logic [CW-1:0] AMB_MIN = 16'd655;
  localparam logic [33:0] Y_EPS = 34'd42949;
  localparam logic [16:0] BLEND_ONE = 17'd65536;

  typedef enum logic [1:0] {
    MODE_REMOVE      = 2'd0,
    MODE_REMOVE_FINE = 2'd1,
    MODE_ADD         = 2'd2,
    MODE_DEPTH       = 2'd3
  } mode_t;

  typedef enum logic [IDXW-1:0] {
    CFG_AMB_R  = 3'd0,
    CFG_AMB_G  = 3'd1,
    CFG_AMB_B  = 3'd2,
    CFG_LUMA   = 3'd3,
    CFG_FLOOR  = 3'd4,
    CFG_BLEND  = 3'd5,
    CFG_MODE   = 3'd6
  } cfg_idx_t;

endpackage

// File: sv/hzr_if.sv
// haze removal pixel recovery: pixel input, pixel output and config channels
// depends on hzr_pkg

interface hzr_pix_in_if;
  import hzr_pkg::*;
  logic          valid;
  logic          ready;
  logic [CW-1:0] red_in;
  logic [CW-1:0] green_in;
  logic [CW-1:0] blue_in;
  logic [CW-1:0] transmission_in;
  modport source (output valid, red_in, green_in, blue_in, transmission_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, transmission_in, output ready);
endinterface

interface hzr_pix_out_if;
  import hzr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] red_out;
  logic signed [OW-1:0] green_out;
  logic signed [OW-1:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface hzr_cfg_if;
  import hzr_pkg::*;
  logic            valid;
  logic            ready;
  logic [IDXW-1:0] index;
  logic [DATW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/hzr_div.sv
// haze removal pixel recovery: pipelined restoring divider, one quotient bit per stage
// standalone; lanes share one valid bit and one sideband tag

module hzr_div #(
  parameter int NW    = 48,
  parameter int DW    = 16,
  parameter int LANES = 1,
  parameter int TW    = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   num,
  input  logic [LANES-1:0][DW-1:0]   den,
  input  logic [TW-1:0]              tag,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   quo,
  output logic [TW-1:0]              tag_out
);

  logic [LANES-1:0][NW-1:0] nq  [NW];
  logic [LANES-1:0][DW-1:0] rem [NW];
  logic [LANES-1:0][DW-1:0] dv  [NW];
  logic [TW-1:0]            tg  [NW];
  logic                     vld [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [LANES-1:0][NW-1:0] nq_prev, nq_next;
    logic [LANES-1:0][DW-1:0] rem_prev, rem_next, dv_prev;
    logic [TW-1:0]            tg_prev;
    logic                     vld_prev;

    if (k == 0) begin : g_first
      assign nq_prev  = num;
      assign rem_prev = '0;
      assign dv_prev  = den;
      assign tg_prev  = tag;
      assign vld_prev = in_valid;
    end else begin : g_rest
      assign nq_prev  = nq[k-1];
      assign rem_prev = rem[k-1];
      assign dv_prev  = dv[k-1];
      assign tg_prev  = tg[k-1];
      assign vld_prev = vld[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      logic [DW:0] rext;
      logic [DW:0] diff;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        rext = {rem_prev[l], nq_prev[l][NW-1]};
        diff = rext - {1'b0, dv_prev[l]};
        ge   = (rext >= {1'b0, dv_prev[l]});
        rem_next[l] = ge ? diff[DW-1:0] : rext[DW-1:0];
        nq_next[l]  = {nq_prev[l][NW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[k]  <= nq_next;
        rem[k] <= rem_next;
        dv[k]  <= dv_prev;
        tg[k]  <= tg_prev;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = nq[NW-1];
  assign tag_out   = tg[NW-1];

endmodule

// File: sv/haze_removal_pixel_recovery.sv
// haze removal pixel recovery: top level, config registers and the pixel pipeline
// depends on hzr_pkg, hzr_if and hzr_div
//
// Takes one normalized pixel and its filtered transmission per clock and returns
// one recovered pixel per item, fully pipelined: a new item is taken in every cycle
// while the output side keeps up. The pipeline is twelve register stages of
// arithmetic plus three bit-per-stage divider pipelines (48 stages for the ambient
// ratios, 59 for the divisions by the transmission, 60 for the luminance gain).
// A stall at the output holds the whole pipeline in place, nothing is lost or
// repeated; ready drops only while the output holds an item that is not taken.
// The config port always accepts; registers should be written while no item is in
// flight. Modes: remove haze (two offset variants), add haze, depth map.

module haze_removal_pixel_recovery (
  input  logic            clk,
  input  logic            rst,
  hzr_pix_in_if.sink      pixel_in,
  hzr_pix_out_if.source   pixel_out,
  hzr_cfg_if.sink         cfg
);
  import hzr_pkg::*;

  // sideband carried through the dividers
  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [CW-1:0]      tin;
  } tag_a_t;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [25:0]        y24;
    logic [25:0]        ay24;
    logic [3:0]         sgn;
    logic               gain;
    logic [16:0]        dep;
  } tag_t_t;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [2:0][37:0]   r2;
    logic               ysg;
    logic               gain;
    logic [16:0]        dep;
  } tag_y_t;

  // ---------------------------------------------------------------- config
  logic [CW-1:0] amb [3];
  logic [47:0]   luma;
  logic [CW-1:0] floor_q;
  logic [16:0]   blend;
  mode_t         mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amb[0]  <= 16'hFFFF;
      amb[1]  <= 16'hFFFF;
      amb[2]  <= 16'hFFFF;
      luma    <= '0;
      floor_q <= 16'd66;
      blend   <= '0;
      mode    <= MODE_REMOVE;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_AMB_R: amb[0]  <= cfg.data[CW-1:0];
        CFG_AMB_G: amb[1]  <= cfg.data[CW-1:0];
        CFG_AMB_B: amb[2]  <= cfg.data[CW-1:0];
        CFG_LUMA:  luma    <= cfg.data[47:0];
        CFG_FLOOR: floor_q <= cfg.data[CW-1:0];
        CFG_BLEND: blend   <= cfg.data[16:0];
        CFG_MODE:  mode    <= mode_t'(cfg.data[1:0]);
        default: ;
      endcase
    end
  end

  // effective settings: clamped ambient, nonzero floor, blend at most one
  logic [CW-1:0] amb_eff [3];
  logic [CW-1:0] wgt [3];
  logic [CW-1:0] fl_eff;
  logic [16:0]   s_eff;
  logic [32:0]   off_sel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amb_eff[i] = (amb[i] < AMB_MIN) ? AMB_MIN : amb[i];
      wgt[i]     = luma[CW*i +: CW];
    end
    fl_eff  = (floor_q == '0) ? 16'd1 : floor_q;
    s_eff   = (blend > BLEND_ONE) ? BLEND_ONE : blend;
    off_sel = (mode == MODE_REMOVE_FINE || mode == MODE_ADD) ? OFFSET_B : OFFSET_A;
  end

  // ---------------------------------------------------------------- flow control
  // one enable for every stage; the last stage is the output register
  logic en;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12;
  logic va, vt, vy;

  assign en             = ~v12 | pixel_out.ready;
  assign pixel_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
      v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0; v12 <= 1'b0;
    end else if (en) begin
      v1  <= pixel_in.valid;
      v2  <= va;
      v3  <= v2;
      v4  <= v3;
      v5  <= vt;
      v6  <= v5;
      v7  <= v6;
      v8  <= vy;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
    end
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic [2:0][CW-1:0] s1_c;
  logic [CW-1:0]      s1_tin;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_c[0] <= pixel_in.red_in;
      s1_c[1] <= pixel_in.green_in;
      s1_c[2] <= pixel_in.blue_in;
      s1_tin  <= pixel_in.transmission_in;
    end
  end

  // ---------------------------------------------------------------- ratio c/A, Q.32
  logic [2:0][47:0]   da_num, da_quo;
  logic [2:0][CW-1:0] da_den;
  tag_a_t             da_tin, da_tout;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      da_num[i] = {s1_c[i], 32'b0};
      da_den[i] = amb_eff[i];
    end
    da_tin.c   = s1_c;
    da_tin.tin = s1_tin;
  end

  hzr_div #(.NW(48), .DW(CW), .LANES(3), .TW($bits(tag_a_t))) u_div_ratio (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1),
    .num(da_num), .den(da_den), .tag(da_tin),
    .out_valid(va), .quo(da_quo), .tag_out(da_tout)
  );

  // ---------------------------------------------------------------- stage 2: min ratio, luma products
  logic [38:0]        s2_minr;
  logic [2:0][CW-1:0] s2_c;
  logic [CW-1:0]      s2_tin;
  logic [2:0][31:0]   s2_pw, s2_pa;
  logic [38:0]        mn01, mn;

  always_comb begin
    mn01 = (da_quo[1][38:0] < da_quo[0][38:0]) ? da_quo[1][38:0] : da_quo[0][38:0];
    mn   = (da_quo[2][38:0] < mn01) ? da_quo[2][38:0] : mn01;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_minr <= mn;
      s2_c    <= da_tout.c;
      s2_tin  <= da_tout.tin;
      for (int i = 0; i < 3; i++) begin
        s2_pw[i] <= 32'(wgt[i]) * 32'(da_tout.c[i]);
        s2_pa[i] <= 32'(wgt[i]) * 32'(amb_eff[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: transmission, luminance
  logic signed [40:0] tl;
  logic [31:0]        tbase;
  logic [32:0]        t_new;
  logic [32:0]        s3_t;
  logic [33:0]        s3_y, s3_ay;
  logic [2:0][CW-1:0] s3_c;

  always_comb begin
    tl    = $signed({8'b0, off_sel}) - $signed({2'b0, s2_minr});
    tbase = ({fl_eff, 16'b0} > {s2_tin, 16'b0}) ? {fl_eff, 16'b0} : {s2_tin, 16'b0};
    t_new = (tl > $signed({9'b0, tbase})) ? tl[32:0] : {1'b0, tbase};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t  <= t_new;
      s3_y  <= 34'(s2_pw[0]) + 34'(s2_pw[1]) + 34'(s2_pw[2]);
      s3_ay <= 34'(s2_pa[0]) + 34'(s2_pa[1]) + 34'(s2_pa[2]);
      s3_c  <= s2_c;
    end
  end

  // ---------------------------------------------------------------- stage 4: dividends over t
  // lanes 0..2: |c-A|<<32, lane 3: |Y-AY|<<32, each with t/2 added for rounding
  logic [3:0][58:0]   s4_num;
  logic [32:0]        s4_t;
  tag_t_t             s4_tag;
  logic signed [16:0] dc [3];
  logic [CW-1:0]      dmag [3];
  logic [25:0]        y24, ay24, dymag;
  logic signed [26:0] dy;
  logic [33:0]        one_m;
  logic [16:0]        dep;

  always_comb begin
    y24  = s3_y[33:8];
    ay24 = s3_ay[33:8];
    dy   = $signed({1'b0, y24}) - $signed({1'b0, ay24});
    dymag = dy[26] ? 26'(-dy) : dy[25:0];
    for (int i = 0; i < 3; i++) begin
      dc[i]   = $signed({1'b0, s3_c[i]}) - $signed({1'b0, amb_eff[i]});
      dmag[i] = dc[i][16] ? 16'(-dc[i]) : dc[i][15:0];
    end
    // depth: round(1 - t) in Q.16, zero once t reaches one
    one_m = 34'h1_0000_0000 - {1'b0, s3_t} + 34'd32768;
    dep   = (s3_t >= 33'h1_0000_0000) ? 17'd0 : one_m[32:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_num[i]     <= 59'({dmag[i], 32'b0}) + 59'(s3_t[32:1]);
        s4_tag.sgn[i] <= dc[i][16];
      end
      s4_num[3]     <= 59'({dymag, 32'b0}) + 59'(s3_t[32:1]);
      s4_tag.sgn[3] <= dy[26];
      s4_t          <= s3_t;
      s4_tag.c      <= s3_c;
      s4_tag.y24    <= y24;
      s4_tag.ay24   <= ay24;
      s4_tag.gain   <= (s3_y > Y_EPS);
      s4_tag.dep    <= dep;
    end
  end

  logic [3:0][32:0] dt_den;
  logic [3:0][58:0] dt_quo;
  tag_t_t           dt_tout;

  always_comb begin
    for (int i = 0; i < 4; i++) dt_den[i] = s4_t;
  end

  hzr_div #(.NW(59), .DW(33), .LANES(4), .TW($bits(tag_t_t))) u_div_trans (
    .clk(clk), .rst(rst), .en(en), .in_valid(v4),
    .num(s4_num), .den(dt_den), .tag(s4_tag),
    .out_valid(vt), .quo(dt_quo), .tag_out(dt_tout)
  );

  // ---------------------------------------------------------------- stage 5: per-channel and luma recovery
  logic signed [37:0] r2a [3];
  logic signed [37:0] r2v [3];
  logic signed [47:0] yq, yv;
  logic [2:0][37:0]   s5_r2;
  logic signed [47:0] s5_yy;
  logic [2:0][CW-1:0] s5_c;
  logic [25:0]        s5_y24;
  logic               s5_gain;
  logic [16:0]        s5_dep;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r2a[i] = (dt_tout.sgn[i] ? -$signed({4'b0, dt_quo[i][33:0]})
                               :  $signed({4'b0, dt_quo[i][33:0]}))
             + $signed({22'b0, amb_eff[i]});
      // add haze mirrors the correction about the input
      r2v[i] = (mode == MODE_ADD) ? $signed({21'b0, dt_tout.c[i], 1'b0}) - r2a[i] : r2a[i];
    end
    yq = dt_tout.sgn[3] ? -$signed({4'b0, dt_quo[3][43:0]}) : $signed({4'b0, dt_quo[3][43:0]});
    yv = yq + $signed({22'b0, dt_tout.ay24});
    if (mode == MODE_ADD) begin
      yv = $signed({21'b0, dt_tout.y24, 1'b0}) - yv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s5_r2[i] <= r2v[i];
      s5_yy   <= dt_tout.gain ? yv : 48'sd0;
      s5_c    <= dt_tout.c;
      s5_y24  <= dt_tout.y24;
      s5_gain <= dt_tout.gain;
      s5_dep  <= dt_tout.dep;
    end
  end

  // ---------------------------------------------------------------- stage 6: c * |YY| in two halves
  logic [46:0]        yabs;
  logic [2:0][37:0]   s6_plo, s6_phi;
  tag_y_t             s6_tag;
  logic [25:0]        s6_y24;

  assign yabs = s5_yy[47] ? 47'(-s5_yy) : s5_yy[46:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_plo[i] <= 38'(s5_c[i]) * 38'(yabs[21:0]);
        s6_phi[i] <= 38'(s5_c[i]) * 38'(yabs[43:22]);
      end
      s6_tag.c    <= s5_c;
      s6_tag.r2   <= s5_r2;
      s6_tag.ysg  <= s5_yy[47];
      s6_tag.gain <= s5_gain;
      s6_tag.dep  <= s5_dep;
      s6_y24      <= s5_y24;
    end
  end

  // ---------------------------------------------------------------- stage 7: gain dividends
  logic [2:0][59:0]   s7_num;
  logic [2:0][25:0]   s7_den;
  tag_y_t             s7_tag;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s7_num[i] <= {s6_phi[i][37:0], 22'b0} + 60'(s6_plo[i]) + 60'(s6_y24[25:1]);
        s7_den[i] <= s6_y24;
      end
      s7_tag <= s6_tag;
    end
  end

  logic [2:0][59:0] dy_quo;
  tag_y_t           dy_tout;

  hzr_div #(.NW(60), .DW(26), .LANES(3), .TW($bits(tag_y_t))) u_div_gain (
    .clk(clk), .rst(rst), .en(en), .in_valid(v7),
    .num(s7_num), .den(s7_den), .tag(s7_tag),
    .out_valid(vy), .quo(dy_quo), .tag_out(dy_tout)
  );

  // ---------------------------------------------------------------- stage 8: luminance-preserving result
  localparam logic signed [60:0] MID_LIM = 61'sd1 <<< 40;

  logic signed [60:0] r1q [3];
  logic signed [60:0] r1c [3];
  logic signed [41:0] s8_r1 [3];
  logic signed [37:0] s8_r2 [3];
  logic [16:0]        s8_dep;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r1q[i] = dy_tout.ysg ? -$signed({1'b0, dy_quo[i]}) : $signed({1'b0, dy_quo[i]});
      if (r1q[i] > MID_LIM) begin
        r1c[i] = MID_LIM;
      end else if (r1q[i] < -MID_LIM) begin
        r1c[i] = -MID_LIM;
      end else begin
        r1c[i] = r1q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // dark pixel keeps its own value
        s8_r1[i] <= dy_tout.gain ? r1c[i][41:0] : $signed({26'b0, dy_tout.c[i]});
        s8_r2[i] <= $signed(dy_tout.r2[i]);
      end
      s8_dep <= dy_tout.dep;
    end
  end

  // ---------------------------------------------------------------- stage 9: blend difference
  logic signed [42:0] dd [3];
  logic               s9_dsg [3];
  logic [41:0]        s9_dmag [3];
  logic signed [41:0] s9_r1 [3];
  logic [16:0]        s9_dep;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i] = 43'(s8_r2[i]) - 43'(s8_r1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s9_dsg[i]  <= dd[i][42];
        s9_dmag[i] <= dd[i][42] ? 42'(-dd[i]) : dd[i][41:0];
        s9_r1[i]   <= s8_r1[i];
      end
      s9_dep <= s8_dep;
    end
  end

  // ---------------------------------------------------------------- stage 10: |diff| * s in two halves
  logic [37:0]        s10_plo [3];
  logic [37:0]        s10_phi [3];
  logic               s10_dsg [3];
  logic signed [41:0] s10_r1 [3];
  logic [16:0]        s10_dep;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s10_plo[i] <= 38'(s9_dmag[i][20:0]) * 38'(s_eff);
        s10_phi[i] <= 38'(s9_dmag[i][41:21]) * 38'(s_eff);
        s10_dsg[i] <= s9_dsg[i];
        s10_r1[i]  <= s9_r1[i];
      end
      s10_dep <= s9_dep;
    end
  end

  // ---------------------------------------------------------------- stage 11: rounded blend term
  logic [59:0]        bsum [3];
  logic signed [44:0] s11_bl [3];
  logic signed [41:0] s11_r1 [3];
  logic [16:0]        s11_dep;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bsum[i] = {1'b0, s10_phi[i], 21'b0} + 60'(s10_plo[i]) + 60'd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s11_bl[i] <= s10_dsg[i] ? -$signed({1'b0, bsum[i][59:16]})
                                :  $signed({1'b0, bsum[i][59:16]});
        s11_r1[i] <= s10_r1[i];
      end
      s11_dep <= s10_dep;
    end
  end

  // ---------------------------------------------------------------- stage 12: saturate, output register
  localparam logic signed [45:0] OUT_MAX = 46'sd524287;
  localparam logic signed [45:0] OUT_MIN = -46'sd524288;

  logic signed [45:0]   vsum [3];
  logic signed [OW-1:0] vsat [3];
  logic signed [OW-1:0] o_pix [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsum[i] = 46'(s11_r1[i]) + 46'(s11_bl[i]);
      if (mode == MODE_DEPTH) begin
        vsat[i] = $signed({3'b0, s11_dep});
      end else if (vsum[i] > OUT_MAX) begin
        vsat[i] = OUT_MAX[OW-1:0];
      end else if (vsum[i] < OUT_MIN) begin
        vsat[i] = OUT_MIN[OW-1:0];
      end else begin
        vsat[i] = vsum[i][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) o_pix[i] <= vsat[i];
    end
  end

  assign pixel_out.valid     = v12;
  assign pixel_out.red_out   = o_pix[0];
  assign pixel_out.green_out = o_pix[1];
  assign pixel_out.blue_out  = o_pix[2];

endmodule
